// ===== design/vls_pkg.sv =====
// Package for the longitudinal vehicle step block: sequencer states, register
// indexes, field widths and fixed-point constants.
// No dependencies; imported by every module of the block.
`default_nettype none

package vls_pkg;

    // Field and unit widths.
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 24;
    localparam int unsigned InW      = 48;
    localparam int unsigned OutW     = 96;
    localparam int unsigned MulW     = 32;
    localparam int unsigned DivNumW  = 56;
    localparam int unsigned DivDenW  = 32;
    localparam int unsigned NetW     = 58;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] REG_MASS   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_POWER  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_DRAG   = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_ROLL   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_RADIUS = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_STEP   = 3'd5;

    // Fixed-point constants, Q.16.
    localparam logic [31:0] SPEED_FLOOR = 32'd6554;
    localparam logic [31:0] GRAVITY     = 32'd642908;
    localparam logic [31:0] GRAVITY_MU  = 32'd450036;
    localparam logic [31:0] RPM_FACTOR  = 32'd625823;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_TP,
        ST_ENG_GO,
        ST_ENG_WAIT,
        ST_VV,
        ST_DHI,
        ST_DLO,
        ST_RCM,
        ST_ROLL,
        ST_BM,
        ST_BRK,
        ST_NET,
        ST_ACC_GO,
        ST_ACC_WAIT,
        ST_DV,
        ST_SPD,
        ST_NUM,
        ST_FHI,
        ST_FLO,
        ST_RPM_GO,
        ST_RPM_WAIT
    } vls_state_t;

    // Request to the shared divider.
    typedef struct packed {
        logic               start;
        logic [DivNumW-1:0] dividend;
        logic [DivDenW-1:0] divisor;
    } div_req_t;

endpackage : vls_pkg

`default_nettype wire

// ===== design/vls_mul.sv =====
// Shared 32 x 32 unsigned multiplier with a registered product.
// Depends on vls_pkg for the operand width.
`default_nettype none

module vls_mul
    import vls_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [MulW-1:0]   a,
    input  wire logic [MulW-1:0]   b,
    output logic      [2*MulW-1:0] p
);

    logic [2*MulW-1:0] p_reg;

    // The product holds until the next enabled cycle, so later steps may read it.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;

endmodule : vls_mul

`default_nettype wire

// ===== design/vls_div.sv =====
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Depends on vls_pkg for widths and the request struct.
`default_nettype none

module vls_div
    import vls_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire div_req_t           req,
    output logic                    busy,
    output logic [DivNumW-1:0]      quot
);

    localparam int unsigned CntW = $clog2(DivNumW + 1);

    logic               busy_reg, busy_next;
    logic [CntW-1:0]    cnt_reg, cnt_next;
    logic [DivNumW-1:0] q_reg, q_next;
    logic [DivDenW-1:0] rem_reg, rem_next;
    logic [DivDenW-1:0] den_reg, den_next;
    logic [DivDenW:0]   shifted;
    logic               ge;

    assign shifted = {rem_reg, q_reg[DivNumW-1]};
    assign ge      = (shifted >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CntW'(DivNumW);
            q_next    = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DivDenW'(shifted - {1'b0, den_reg}) : shifted[DivDenW-1:0];
            q_next   = {q_reg[DivNumW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule : vls_div

`default_nettype wire

// ===== design/vehicle_longitudinal_step.sv =====
// Top level of the longitudinal vehicle step: sequencer, state and datapath
// registers. Depends on vls_pkg, vls_mul and vls_div.
//
//   Channel   Direction  Handshake               Payload
//   s_*       in         s_tvalid / s_tready     s_tdata: throttle, brake, gear_ratio
//   m_*       out        m_tvalid / m_tready     m_tdata: speed, accel, engine_rpm
//   cfg_*     in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Each accepted item runs through three 56-step divisions in the shared radix-2
// divider (engine force, acceleration, engine rpm), during each of which the
// sequencer waits, plus seventeen further sequencer steps around the one shared
// multiplier. The input is ready only while the sequencer is idle, so a new item
// is taken only once the previous one is through.
// A finished result waits in the output register; the sequencer stalls on its
// final step only if the previous result has not been taken yet.
// Reset is asynchronous and active low; it clears the held speed to zero and
// loads the configuration registers with their default values.
`default_nettype none

module vehicle_longitudinal_step
    import vls_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [InW-1:0]      s_tdata,   // [15:0] throttle, [31:16] brake,
                                                // [47:32] gear_ratio
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [OutW-1:0]     m_tdata,   // [31:0] speed, [63:32] accel,
                                                // [95:64] engine_rpm
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data
);

    vls_state_t state_reg, state_next;

    // Configuration registers.
    logic [15:0] mass_reg, mass_next;
    logic [23:0] power_reg, power_next;
    logic [23:0] drag_reg, drag_next;
    logic [15:0] roll_reg, roll_next;
    logic [15:0] radius_reg, radius_next;
    logic [15:0] step_reg, step_next;

    // Held speed and output stage.
    logic [31:0]     speed_reg, speed_next;
    logic            m_valid_reg, m_valid_next;
    logic [OutW-1:0] m_data_reg, m_data_next;

    // Per-item working registers.
    logic [15:0]     thr_reg, thr_next;
    logic [15:0]     brk_reg, brk_next;
    logic [15:0]     ratio_reg, ratio_next;
    logic [23:0]     lo_reg, lo_next;
    logic [NetW-1:0] net_reg, net_next;
    logic [51:0]     p_reg, p_next;
    logic [31:0]     acc_reg, acc_next;

    // Shared units.
    logic              mul_en;
    logic [MulW-1:0]   mul_a, mul_b;
    logic [2*MulW-1:0] mul_p;
    div_req_t          div_req;
    logic              div_busy;
    logic [DivNumW-1:0] div_q;

    // Derived operands.
    logic [15:0]        mass_eff, radius_eff;
    logic [31:0]        speed_floor;
    logic [NetW-1:0]    net_neg;
    logic [DivNumW-1:0] net_abs;
    logic [31:0]        acc_abs, acc_sat, rpm_sat, dv_mag, new_speed;
    logic [32:0]        speed_sum;

    vls_mul u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    vls_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .busy  (div_busy),
        .quot  (div_q)
    );

    // A zero mass or radius behaves as one.
    assign mass_eff    = (mass_reg == 16'd0) ? 16'd1 : mass_reg;
    assign radius_eff  = (radius_reg == 16'd0) ? 16'd1 : radius_reg;
    assign speed_floor = (speed_reg > SPEED_FLOOR) ? speed_reg : SPEED_FLOOR;

    // Net force magnitude; it always stays below 2^56.
    assign net_neg = NetW'(~net_reg + 1'b1);
    assign net_abs = net_reg[NetW-1] ? net_neg[DivNumW-1:0] : net_reg[DivNumW-1:0];

    // Acceleration is the signed quotient truncated toward zero, then saturated.
    always_comb
    begin
        if (!net_reg[NetW-1])
        begin
            acc_sat = (div_q > DivNumW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : div_q[31:0];
        end
        else
        begin
            acc_sat = (div_q > DivNumW'(32'h8000_0000)) ? 32'h8000_0000
                                                         : 32'(~div_q[31:0] + 1'b1);
        end
    end

    assign acc_abs = acc_reg[31] ? 32'(~acc_reg + 1'b1) : acc_reg;
    assign rpm_sat = (|div_q[DivNumW-1:32]) ? 32'hFFFF_FFFF : div_q[31:0];

    // Speed update: the delta is truncated toward zero, the sum clamped both ways.
    assign dv_mag    = mul_p[47:16];
    assign speed_sum = {1'b0, speed_reg} + {1'b0, dv_mag};
    always_comb
    begin
        if (acc_reg[31])
        begin
            new_speed = (speed_reg >= dv_mag) ? 32'(speed_reg - dv_mag) : 32'd0;
        end
        else
        begin
            new_speed = speed_sum[32] ? 32'hFFFF_FFFF : speed_sum[31:0];
        end
    end

    // Sequencer: each state drives at most one multiplier or divider operation and
    // may consume the product of the step before.
    always_comb
    begin
        state_next   = state_reg;
        mass_next    = mass_reg;
        power_next   = power_reg;
        drag_next    = drag_reg;
        roll_next    = roll_reg;
        radius_next  = radius_reg;
        step_next    = step_reg;
        speed_next   = speed_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        thr_next     = thr_reg;
        brk_next     = brk_reg;
        ratio_next   = ratio_reg;
        lo_next      = lo_reg;
        net_next     = net_reg;
        p_next       = p_reg;
        acc_next     = acc_reg;
        mul_en       = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        div_req      = '0;
        s_tready     = 1'b0;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MASS:   mass_next   = cfg_data[15:0];
                REG_POWER:  power_next  = cfg_data;
                REG_DRAG:   drag_next   = cfg_data;
                REG_ROLL:   roll_next   = cfg_data[15:0];
                REG_RADIUS: radius_next = cfg_data[15:0];
                REG_STEP:   step_next   = cfg_data[15:0];
                default:    ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    thr_next   = s_tdata[15:0];
                    brk_next   = s_tdata[31:16];
                    ratio_next = s_tdata[47:32];
                    state_next = ST_TP;
                end
            end
            ST_TP:
            begin
                mul_en     = 1'b1;
                mul_a      = {16'd0, thr_reg};
                mul_b      = {8'd0, power_reg};
                state_next = ST_ENG_GO;
            end
            ST_ENG_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {mul_p[39:0], 16'd0};
                div_req.divisor  = speed_floor;
                state_next       = ST_ENG_WAIT;
            end
            ST_ENG_WAIT:
            begin
                if (!div_busy)
                begin
                    net_next   = {2'd0, div_q};
                    state_next = ST_VV;
                end
            end
            ST_VV:
            begin
                mul_en     = 1'b1;
                mul_a      = speed_reg;
                mul_b      = speed_reg;
                state_next = ST_DHI;
            end
            ST_DHI:
            begin
                // Speed squared in Q.16 is split into two 24-bit halves.
                lo_next    = mul_p[39:16];
                mul_en     = 1'b1;
                mul_a      = {8'd0, mul_p[63:40]};
                mul_b      = {8'd0, drag_reg};
                state_next = ST_DLO;
            end
            ST_DLO:
            begin
                net_next   = NetW'(net_reg - {3'd0, mul_p[47:0], 7'd0});
                mul_en     = 1'b1;
                mul_a      = {8'd0, lo_reg};
                mul_b      = {8'd0, drag_reg};
                state_next = ST_RCM;
            end
            ST_RCM:
            begin
                net_next   = NetW'(net_reg - {27'd0, mul_p[47:17]});
                mul_en     = 1'b1;
                mul_a      = {16'd0, roll_reg};
                mul_b      = {16'd0, mass_eff};
                state_next = ST_ROLL;
            end
            ST_ROLL:
            begin
                mul_en     = 1'b1;
                mul_a      = mul_p[31:0];
                mul_b      = GRAVITY;
                state_next = ST_BM;
            end
            ST_BM:
            begin
                net_next   = NetW'(net_reg - {10'd0, mul_p[63:16]});
                mul_en     = 1'b1;
                mul_a      = {16'd0, brk_reg};
                mul_b      = {16'd0, mass_eff};
                state_next = ST_BRK;
            end
            ST_BRK:
            begin
                mul_en     = 1'b1;
                mul_a      = mul_p[31:0];
                mul_b      = GRAVITY_MU;
                state_next = ST_NET;
            end
            ST_NET:
            begin
                net_next   = NetW'(net_reg - {10'd0, mul_p[63:16]});
                state_next = ST_ACC_GO;
            end
            ST_ACC_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = net_abs;
                div_req.divisor  = {16'd0, mass_eff};
                state_next       = ST_ACC_WAIT;
            end
            ST_ACC_WAIT:
            begin
                if (!div_busy)
                begin
                    acc_next   = acc_sat;
                    state_next = ST_DV;
                end
            end
            ST_DV:
            begin
                mul_en     = 1'b1;
                mul_a      = acc_abs;
                mul_b      = {16'd0, step_reg};
                state_next = ST_SPD;
            end
            ST_SPD:
            begin
                speed_next = new_speed;
                state_next = ST_NUM;
            end
            ST_NUM:
            begin
                mul_en     = 1'b1;
                mul_a      = speed_reg;
                mul_b      = {16'd0, ratio_reg};
                state_next = ST_FHI;
            end
            ST_FHI:
            begin
                lo_next    = mul_p[23:0];
                mul_en     = 1'b1;
                mul_a      = {8'd0, mul_p[47:24]};
                mul_b      = RPM_FACTOR;
                state_next = ST_FLO;
            end
            ST_FLO:
            begin
                p_next     = {mul_p[43:0], 8'd0};
                mul_en     = 1'b1;
                mul_a      = {8'd0, lo_reg};
                mul_b      = RPM_FACTOR;
                state_next = ST_RPM_GO;
            end
            ST_RPM_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {4'd0, 52'(p_reg + {24'd0, mul_p[43:16]})};
                div_req.divisor  = {16'd0, radius_eff};
                state_next       = ST_RPM_WAIT;
            end
            ST_RPM_WAIT:
            begin
                if (!div_busy && (!m_valid_reg || m_tready))
                begin
                    m_data_next  = {rpm_sat, acc_reg, speed_reg};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            mass_reg    <= 16'd1000;
            power_reg   <= 24'd100000;
            drag_reg    <= 24'd32768;
            roll_reg    <= 16'd983;
            radius_reg  <= 16'd19661;
            step_reg    <= 16'd655;
            speed_reg   <= 32'd0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            mass_reg    <= mass_next;
            power_reg   <= power_next;
            drag_reg    <= drag_next;
            roll_reg    <= roll_next;
            radius_reg  <= radius_next;
            step_reg    <= step_next;
            speed_reg   <= speed_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        thr_reg    <= thr_next;
        brk_reg    <= brk_next;
        ratio_reg  <= ratio_next;
        lo_reg     <= lo_next;
        net_reg    <= net_next;
        p_reg      <= p_next;
        acc_reg    <= acc_next;
    end

    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign cfg_ready = 1'b1;

endmodule : vehicle_longitudinal_step

`default_nettype wire

// ===== design/vls_check.sv =====
// Port-level checker for the longitudinal vehicle step, bound to the top level.
// Depends on vls_pkg and vehicle_longitudinal_step.
`default_nettype none

module vls_check
    import vls_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    input  wire logic                s_tready,
    input  wire logic                m_tvalid,
    input  wire logic                m_tready,
    input  wire logic [OutW-1:0]     m_tdata,
    input  wire logic                cfg_valid,
    input  wire logic                cfg_ready
);

    logic [1:0] open_reg;

    // Items accepted whose result has not been taken yet.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 2'd0;
        end
        else
        begin
            open_reg <= 2'(open_reg + {1'b0, s_tvalid & s_tready}
                                    - {1'b0, m_tvalid & m_tready});
        end
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready right after an item was accepted");

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed or dropped");

    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (open_reg != 2'd0))
        else $error("result shown without an accepted item");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg != 2'd3)
        else $error("more than two items outstanding");

    a_cfg_when_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |-> (open_reg == 2'd0))
        else $error("register written while an item was in flight");

endmodule : vls_check

bind vehicle_longitudinal_step vls_check u_vls_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench for vehicle_longitudinal_step: drives simulation ticks,
// predicts speed, acceleration and engine rpm, and compares every result item.
// Depends on vls_pkg and the block's RTL.
`default_nettype none

module tb_top;
    import vls_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Drain wait after the last result, before registers are touched.
    localparam int unsigned DrainCycles = 600;
    localparam longint unsigned CycleLimit = 10_000_000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [InW-1:0]      s_tdata = '0;      // [15:0] throttle, [31:16] brake, [47:32] gear_ratio
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OutW-1:0]     m_tdata;           // [31:0] speed, [63:32] accel, [95:64] engine_rpm
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;

    typedef struct packed {
        logic [15:0] gear_ratio;
        logic [15:0] brake;
        logic [15:0] throttle;
    } tick_t;

    typedef struct packed {
        logic [31:0] engine_rpm;
        logic [31:0] accel;
        logic [31:0] speed;
    } motion_t;

    // Predictor copy of the configuration and the held speed.
    logic [15:0] mdl_mass;
    logic [23:0] mdl_power;
    logic [23:0] mdl_drag;
    logic [15:0] mdl_roll;
    logic [15:0] mdl_radius;
    logic [15:0] mdl_step;
    logic [31:0] mdl_speed;

    tick_t   pending_ticks[$];
    motion_t expected_motion[$];
    int unsigned error_count = 0;
    int unsigned results_seen = 0;
    int unsigned ticks_sent = 0;
    longint unsigned cycle_count = 0;
    bit stall_enable = 1'b1;

    vehicle_longitudinal_step u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Most gaps are short; now and then a long one.
    function automatic int unsigned gap_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!stall_enable || roll < 50)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 4);
        else
            return $urandom_range(20, 300);
    endfunction

    function automatic int signed saturate32(longint signed x);
        if (x > 64'sd2147483647)
            return 32'sh7fffffff;
        if (x < -64'sd2147483648)
            return 32'sh80000000;
        return int'(x);
    endfunction

    // Engine rpm from speed, ratio and radius; quotient and remainder are scaled
    // separately so that nothing overflows 64 bits.
    function automatic logic [31:0] rpm_from_speed(logic [31:0] v, logic [15:0] ratio,
                                                   logic [15:0] radius);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quo;
        logic [63:0] rem;
        logic [63:0] res;
        num = 64'(v) * 64'(ratio);
        den = 64'(radius) << 16;
        quo = num / den;
        rem = num % den;
        if (quo >= 64'd8192)
            return 32'hffffffff;
        res = quo * 64'(RPM_FACTOR) + (rem * 64'(RPM_FACTOR)) / den;
        if (res > 64'hffffffff)
            return 32'hffffffff;
        return res[31:0];
    endfunction

    // One Euler step of the vehicle; updates the held speed.
    function automatic motion_t advance_vehicle(tick_t t);
        motion_t r;
        logic [63:0] mass;
        logic [63:0] radius;
        logic [63:0] vfloor;
        logic [63:0] v2;
        logic [63:0] engine;
        logic [63:0] drag;
        logic [63:0] rolling;
        logic [63:0] braking;
        longint signed net;
        longint signed acc;
        longint signed dv;
        longint signed nv;
        int signed acc_sat;
        mass = (mdl_mass == 0) ? 64'd1 : 64'(mdl_mass);
        radius = (mdl_radius == 0) ? 64'd1 : 64'(mdl_radius);
        vfloor = (mdl_speed > SPEED_FLOOR) ? 64'(mdl_speed) : 64'(SPEED_FLOOR);
        engine = ((64'(t.throttle) * 64'(mdl_power)) << 16) / vfloor;
        v2 = (64'(mdl_speed) * 64'(mdl_speed)) >> 16;
        drag = (((v2 >> 24) * 64'(mdl_drag)) << 7)
             + (((v2 & 64'hffffff) * 64'(mdl_drag)) >> 17);
        rolling = (64'(mdl_roll) * mass * 64'(GRAVITY)) >> 16;
        braking = (64'(t.brake) * mass * 64'(GRAVITY_MU)) >> 16;
        net = longint'(engine) - longint'(drag) - longint'(rolling) - longint'(braking);
        acc = net / longint'(mass);
        acc_sat = saturate32(acc);
        dv = (longint'(acc_sat) * longint'(mdl_step)) / 64'sd65536;
        nv = longint'(mdl_speed) + dv;
        if (nv < 0)
            nv = 0;
        if (nv > 64'sh00000000ffffffff)
            nv = 64'sh00000000ffffffff;
        mdl_speed = nv[31:0];
        r.speed = mdl_speed;
        r.accel = acc_sat;
        r.engine_rpm = rpm_from_speed(mdl_speed, t.gear_ratio, radius[15:0]);
        return r;
    endfunction

    function automatic void model_register_write(logic [CfgIdxW-1:0] idx,
                                                 logic [CfgDataW-1:0] val);
        case (idx)
            REG_MASS:   mdl_mass = val[15:0];
            REG_POWER:  mdl_power = val;
            REG_DRAG:   mdl_drag = val;
            REG_ROLL:   mdl_roll = val[15:0];
            REG_RADIUS: mdl_radius = val[15:0];
            REG_STEP:   mdl_step = val[15:0];
            default: ;
        endcase
    endfunction

    // Register write on the configuration channel, only while the block is idle.
    task automatic write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        model_register_write(idx, val);
    endtask

    // Wait until every queued tick has been sent and every result has come back,
    // then give the block time to settle before touching registers.
    task automatic wait_idle();
        while (pending_ticks.size() != 0 || s_tvalid || expected_motion.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    function automatic tick_t random_tick();
        tick_t t;
        int unsigned roll;
        t = tick_t'(48'({$urandom, $urandom}));
        roll = $urandom_range(0, 9);
        // Mostly plausible driving: moderate brake, to reach mid-range speeds.
        if (roll < 4)
            t.brake = 16'd0;
        else if (roll < 6)
            t.brake = 16'($urandom_range(0, 4000));
        if ($urandom_range(0, 9) < 3)
            t.gear_ratio = 16'($urandom_range(256, 4096));
        return t;
    endfunction

    // Driver: takes the next tick when the previous one was accepted.
    int unsigned send_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || s_tready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_ticks.size() != 0)
                begin
                    tick_t t;
                    t = pending_ticks.pop_front();
                    s_tdata <= t;
                    s_tvalid <= 1'b1;
                    expected_motion.push_back(advance_vehicle(t));
                    ticks_sent <= ticks_sent + 1;
                    send_gap <= gap_length();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each accepted result item with the oldest prediction.
    int unsigned recv_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                motion_t got;
                motion_t want;
                got = m_tdata;
                results_seen <= results_seen + 1;
                if (expected_motion.size() == 0)
                begin
                    $error("unexpected result item: %h", m_tdata);
                    error_count = error_count + 1;
                end
                else
                begin
                    want = expected_motion.pop_front();
                    if (got.speed !== want.speed)
                    begin
                        $error("speed: expected %h, actual %h", want.speed, got.speed);
                        error_count = error_count + 1;
                    end
                    if (got.accel !== want.accel)
                    begin
                        $error("accel: expected %h, actual %h", want.accel, got.accel);
                        error_count = error_count + 1;
                    end
                    if (got.engine_rpm !== want.engine_rpm)
                    begin
                        $error("engine_rpm: expected %h, actual %h",
                               want.engine_rpm, got.engine_rpm);
                        error_count = error_count + 1;
                    end
                end
            end
            if (recv_gap != 0)
            begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                recv_gap <= gap_length();
            end
        end
    end

    // Watchdog on total cycles.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // A phase of random ticks under one register setting.
    task automatic random_phase(int unsigned count);
        repeat (count) pending_ticks.push_back(random_tick());
        wait_idle();
    endtask

    initial
    begin
        tick_t t;
        mdl_mass = 16'd1000;
        mdl_power = 24'd100000;
        mdl_drag = 24'd32768;
        mdl_roll = 16'd983;
        mdl_radius = 16'd19661;
        mdl_step = 16'd655;
        mdl_speed = 32'd0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part under reset values: full throttle from standstill, then
        // field extremes, full brake and a zero gear ratio.
        t = '{gear_ratio: 16'd1024, brake: 16'd0, throttle: 16'hffff};
        repeat (6) pending_ticks.push_back(t);
        pending_ticks.push_back('{gear_ratio: 16'hffff, brake: 16'd0, throttle: 16'hffff});
        pending_ticks.push_back('{gear_ratio: 16'd0, brake: 16'd0, throttle: 16'd0});
        pending_ticks.push_back('{gear_ratio: 16'h5555, brake: 16'haaaa, throttle: 16'h5555});
        pending_ticks.push_back('{gear_ratio: 16'haaaa, brake: 16'hffff, throttle: 16'haaaa});
        pending_ticks.push_back('{gear_ratio: 16'd1, brake: 16'hffff, throttle: 16'd0});
        wait_idle();

        // Zero mass and zero radius stand for one; a zero step holds speed.
        write_register(REG_MASS, 24'd0);
        write_register(REG_RADIUS, 24'd0);
        write_register(REG_STEP, 24'd0);
        pending_ticks.push_back('{gear_ratio: 16'd256, brake: 16'd0, throttle: 16'hffff});
        pending_ticks.push_back('{gear_ratio: 16'hffff, brake: 16'hffff, throttle: 16'd0});
        wait_idle();

        // Extreme setting: everything at its top value, plus bits above the widths.
        write_register(REG_MASS, 24'hffffff);
        write_register(REG_POWER, 24'hffffff);
        write_register(REG_DRAG, 24'hffffff);
        write_register(REG_ROLL, 24'hffffff);
        write_register(REG_RADIUS, 24'hffffff);
        write_register(REG_STEP, 24'hffffff);
        write_register(3'd7, 24'h123456);
        write_register(3'd6, 24'h000001);
        random_phase(10);

        // Light, powerful car with no losses: drives speed toward saturation.
        write_register(REG_MASS, 24'd1);
        write_register(REG_DRAG, 24'd0);
        write_register(REG_ROLL, 24'd0);
        write_register(REG_RADIUS, 24'd1);
        write_register(REG_STEP, 24'd65535);
        t = '{gear_ratio: 16'hffff, brake: 16'd0, throttle: 16'hffff};
        repeat (6) pending_ticks.push_back(t);
        wait_idle();

        // Randomized phases, each under a random register setting.
        for (int phase = 0; phase < 12; phase++)
        begin
            stall_enable = (phase % 4) != 3;
            write_register(REG_MASS, 24'($urandom_range(1, 5000)));
            write_register(REG_POWER, (phase % 3 == 0) ? 24'($urandom)
                                                       : 24'($urandom_range(0, 400000)));
            write_register(REG_DRAG, (phase % 2 == 0) ? 24'($urandom)
                                                      : 24'($urandom_range(0, 100000)));
            write_register(REG_ROLL, 24'($urandom_range(0, 65535)));
            write_register(REG_RADIUS, 24'($urandom_range(1, 65535)));
            write_register(REG_STEP, 24'($urandom_range(1, 65535)));
            random_phase(100);
        end
        stall_enable = 1'b1;

        wait_idle();
        $display("Sent %0d ticks, checked %0d results across directed, extreme and",
                 ticks_sent, results_seen);
        $display("random register settings with random stalls on both sides.");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule : tb_top

`default_nettype wire
